@@ rtl/core/rcds_pkg.sv @@
package rcds_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TICK_W     = 24;
    localparam int TPU_W      = 8;
    localparam int OVS_W      = 4;
    localparam int SCOUNT_W   = 9;
    localparam int RAW_W      = 24;
    localparam int STATUS_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ENABLED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 2'd3;

    localparam logic [OVS_W-1:0]  RST_OVERSAMPLE_LOG2 = 4'd5;
    localparam logic [TICK_W-1:0] RST_CHARGE_TICKS    = 24'd9600;
    localparam logic [TICK_W-1:0] RST_SETTLE_TICKS    = 24'd3600;
    localparam logic [TICK_W-1:0] RST_TIMEOUT_TICKS   = 24'd480000;
    localparam logic [TPU_W-1:0]  RST_TICKS_PER_US    = 8'd240;

    typedef struct packed {
        logic              enabled;
        logic [OVS_W-1:0]  oversample_log2;
        logic [TICK_W-1:0] charge_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] timeout_ticks;
        logic [TPU_W-1:0]  ticks_per_us;
    } t_cfg;

    typedef struct packed {
        logic                pos_drive_en;
        logic                pos_level;
        logic                neg_drive_en;
        logic                neg_level;
        logic                probe_drive_en;
        logic                probe_level;
        logic                busy_res;
        logic                done_res;
        logic [RAW_W-1:0]    raw_average;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

@@ rtl/core/rcds_if.sv @@
interface rcds_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic cap_level;

    modport source(output valid, output start_req, output cap_level, input ready);
    modport sink(input valid, input start_req, input cap_level, output ready);
endinterface

interface rcds_out_if;
    logic        valid;
    logic        ready;
    logic        pos_drive_en;
    logic        pos_level;
    logic        neg_drive_en;
    logic        neg_level;
    logic        probe_drive_en;
    logic        probe_level;
    logic        busy_res;
    logic        done_res;
    logic [23:0] raw_average;
    logic [1:0]  status;

    modport source(
        output valid, output pos_drive_en, output pos_level, output neg_drive_en,
        output neg_level, output probe_drive_en, output probe_level, output busy_res,
        output done_res, output raw_average, output status, input ready
    );
    modport sink(
        input valid, input pos_drive_en, input pos_level, input neg_drive_en,
        input neg_level, input probe_drive_en, input probe_level, input busy_res,
        input done_res, input raw_average, input status, output ready
    );
endinterface

interface rcds_cfg_if import rcds_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output idx, output data, input ready);
    modport sink(input valid, input idx, input data, output ready);
endinterface

@@ rtl/core/rcds_seq.sv @@
module rcds_seq
    import rcds_pkg::*;
#(
    parameter int COUNT_WIDTH         = 24,
    parameter int MAX_OVERSAMPLE_LOG2 = 8,
    parameter int ACC_WIDTH           = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_start_req,
    input  logic    i_cap_level,
    input  logic    i_status_clr,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CHARGE,
        PH_DISCHARGE,
        PH_SETTLE,
        PH_REVCHARGE,
        PH_COMP,
        PH_NEUTRAL
    } t_phase;

    localparam int NW = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
    localparam int SW = ((ACC_WIDTH > COUNT_WIDTH) ? ACC_WIDTH : COUNT_WIDTH) + 1;
    localparam int AW = (ACC_WIDTH > RAW_W) ? ACC_WIDTH : RAW_W;
    localparam logic [NW-1:0]     CNT_MAX   = NW'({COUNT_WIDTH{1'b1}});
    localparam logic [SW-1:0]     ACC_MAX   = SW'({ACC_WIDTH{1'b1}});
    localparam logic [AW-1:0]     RAW_MAX   = AW'({RAW_W{1'b1}});
    localparam logic [TICK_W-1:0] TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [OVS_W-1:0]  OVS_LIMIT = OVS_W'(MAX_OVERSAMPLE_LOG2);

    t_phase                  r_phase, n_phase;
    logic [TICK_W-1:0]       r_pticks, n_pticks;
    logic [COUNT_WIDTH-1:0]  r_dcount, n_dcount;
    logic [COUNT_WIDTH-1:0]  r_rem, n_rem;
    logic [TPU_W-1:0]        r_div, n_div;
    logic [TPU_W-1:0]        r_presc, n_presc;
    logic [SCOUNT_W-1:0]     r_scount, n_scount;
    logic [ACC_WIDTH-1:0]    r_acc, n_acc;
    logic                    r_last_cap;
    logic [STATUS_W-1:0]     r_status, n_status;

    logic                    fall;
    logic [TPU_W-1:0]        tpu;
    logic [OVS_W-1:0]        ovs;
    logic [TICK_W-1:0]       pt_inc;
    logic [NW-1:0]           cnt_ext;
    logic [TPU_W-1:0]        presc_inc;
    logic [COUNT_WIDTH-1:0]  div_x2;
    logic [SW-1:0]           acc_sum;
    logic [ACC_WIDTH-1:0]    acc_new;
    logic [SCOUNT_W-1:0]     scount_new;
    logic [SCOUNT_W-1:0]     target;
    logic [AW-1:0]           avg_ext;
    logic [RAW_W-1:0]        avg;
    logic                    done;
    logic [RAW_W-1:0]        raw;

    assign fall      = r_last_cap & ~i_cap_level;
    assign tpu       = (i_cfg.ticks_per_us == '0) ? TPU_W'(1) : i_cfg.ticks_per_us;
    assign ovs       = (i_cfg.oversample_log2 > OVS_LIMIT) ? OVS_LIMIT : i_cfg.oversample_log2;
    assign pt_inc    = (r_pticks == TICK_MAX) ? r_pticks : r_pticks + TICK_W'(1);
    assign cnt_ext   = NW'(pt_inc);
    assign presc_inc = r_presc + TPU_W'(1);
    assign div_x2    = COUNT_WIDTH'({r_div, 1'b0});
    assign acc_sum   = SW'(r_acc) + SW'(r_dcount);
    assign acc_new   = (acc_sum > ACC_MAX) ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];
    assign scount_new = (r_scount == {SCOUNT_W{1'b1}}) ? r_scount : r_scount + SCOUNT_W'(1);
    assign target    = SCOUNT_W'(1) << ovs;
    assign avg_ext   = AW'(acc_new) >> ovs;
    assign avg       = (avg_ext > RAW_MAX) ? {RAW_W{1'b1}} : avg_ext[RAW_W-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_pticks = r_pticks;
        n_dcount = r_dcount;
        n_rem    = r_rem;
        n_div    = r_div;
        n_presc  = r_presc;
        n_scount = r_scount;
        n_acc    = r_acc;
        n_status = r_status;
        done     = 1'b0;
        raw      = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    if (!i_cfg.enabled) begin
                        done     = 1'b1;
                        n_status = ST_NOT_ENABLED;
                        n_pticks = '0;
                        n_presc  = '0;
                    end else begin
                        n_acc    = '0;
                        n_scount = '0;
                        n_phase  = PH_CHARGE;
                        n_pticks = '0;
                    end
                end
            end
            PH_CHARGE: begin
                n_pticks = pt_inc;
                if (pt_inc >= i_cfg.charge_ticks) begin
                    n_phase  = PH_DISCHARGE;
                    n_pticks = '0;
                end
            end
            PH_DISCHARGE: begin
                if (fall) begin
                    n_dcount = (cnt_ext > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                                   : cnt_ext[COUNT_WIDTH-1:0];
                    n_rem    = n_dcount;
                    n_div    = tpu;
                    n_phase  = PH_SETTLE;
                    n_pticks = '0;
                end else if (pt_inc >= i_cfg.timeout_ticks) begin
                    done     = 1'b1;
                    n_status = ST_TIMEOUT;
                    n_phase  = PH_IDLE;
                    n_pticks = '0;
                    n_presc  = '0;
                end else begin
                    n_pticks = pt_inc;
                end
            end
            PH_SETTLE: begin
                n_pticks = pt_inc;
                if (pt_inc >= i_cfg.settle_ticks) begin
                    n_phase  = PH_REVCHARGE;
                    n_pticks = '0;
                end
            end
            PH_REVCHARGE: begin
                n_pticks = pt_inc;
                if (pt_inc >= i_cfg.charge_ticks) begin
                    n_phase  = PH_COMP;
                    n_pticks = '0;
                    n_presc  = '0;
                end
            end
            PH_COMP: begin
                n_presc = presc_inc;
                if (presc_inc >= tpu) begin
                    n_presc = '0;
                    // end when fewer than two whole microseconds remain
                    if (r_rem < div_x2) begin
                        n_phase  = PH_NEUTRAL;
                        n_pticks = '0;
                    end else begin
                        n_rem = r_rem - COUNT_WIDTH'(r_div);
                    end
                end
            end
            PH_NEUTRAL: begin
                n_pticks = pt_inc;
                if (pt_inc >= i_cfg.settle_ticks) begin
                    n_acc    = acc_new;
                    n_scount = scount_new;
                    n_pticks = '0;
                    if (scount_new >= target) begin
                        done     = 1'b1;
                        n_phase  = PH_IDLE;
                        n_presc  = '0;
                        if (avg == '0) begin
                            n_status = ST_INVALID;
                        end else begin
                            n_status = ST_OK;
                            raw      = avg;
                        end
                    end else begin
                        n_phase = PH_CHARGE;
                    end
                end
            end
            default: begin
                n_phase  = PH_IDLE;
                n_pticks = '0;
            end
        endcase
    end

    always_comb begin
        o_res = '0;
        case (n_phase)
            PH_CHARGE: begin
                o_res.pos_drive_en = 1'b1;
                o_res.pos_level    = 1'b1;
                o_res.neg_drive_en = 1'b1;
            end
            PH_DISCHARGE: begin
                o_res.neg_drive_en   = 1'b1;
                o_res.probe_drive_en = 1'b1;
            end
            PH_SETTLE: begin
                o_res.pos_drive_en = 1'b1;
                o_res.neg_drive_en = 1'b1;
            end
            PH_REVCHARGE: begin
                o_res.pos_drive_en = 1'b1;
                o_res.neg_drive_en = 1'b1;
                o_res.neg_level    = 1'b1;
            end
            PH_COMP: begin
                o_res.neg_drive_en   = 1'b1;
                o_res.neg_level      = 1'b1;
                o_res.probe_drive_en = 1'b1;
                o_res.probe_level    = 1'b1;
            end
            PH_NEUTRAL: begin
                o_res.pos_drive_en = 1'b1;
                o_res.pos_level    = 1'b1;
                o_res.neg_drive_en = 1'b1;
                o_res.neg_level    = 1'b1;
            end
            default: begin
                o_res.pos_drive_en = 1'b0;
            end
        endcase
        o_res.busy_res    = (n_phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.raw_average = raw;
        o_res.status      = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pticks   <= '0;
            r_dcount   <= '0;
            r_rem      <= '0;
            r_div      <= '0;
            r_presc    <= '0;
            r_scount   <= '0;
            r_acc      <= '0;
            r_last_cap <= 1'b1;
            r_status   <= ST_NOT_ENABLED;
        end else begin
            if (i_step) begin
                r_phase    <= n_phase;
                r_pticks   <= n_pticks;
                r_dcount   <= n_dcount;
                r_rem      <= n_rem;
                r_div      <= n_div;
                r_presc    <= n_presc;
                r_scount   <= n_scount;
                r_acc      <= n_acc;
                r_last_cap <= i_cap_level;
                r_status   <= n_status;
            end
            if (i_status_clr) begin
                r_status <= ST_OK;
            end
        end
    end

endmodule

@@ rtl/core/rc_discharge_conductivity_sequencer.sv @@
// A tick's result is registered in the result buffer and offered from its head.
// Throughput: one tick per cycle; a two-entry result buffer keeps input ready
// while fewer than two results wait downstream.
// Reset: sequencer idle, pins released, status not enabled, registers at defaults,
// result buffer empty.
module rc_discharge_conductivity_sequencer
    import rcds_pkg::*;
#(
    parameter int COUNT_WIDTH         = 24,
    parameter int MAX_OVERSAMPLE_LOG2 = 8,
    parameter int ACC_WIDTH           = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcds_in_if.sink     i_in,
    rcds_out_if.source  o_out,
    rcds_cfg_if.sink    i_cfg
);

    t_cfg        r_cfg;
    t_result     seq_res;
    t_result     r_head;
    t_result     r_tail;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;
    logic        cfg_wr;
    logic        status_clr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;
    assign status_clr  = cfg_wr && (i_cfg.idx == REG_ENABLED) && i_cfg.data[0];

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid & i_in.ready;
    assign pop         = o_out.valid & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled         <= 1'b0;
            r_cfg.oversample_log2 <= RST_OVERSAMPLE_LOG2;
            r_cfg.charge_ticks    <= RST_CHARGE_TICKS;
            r_cfg.settle_ticks    <= RST_SETTLE_TICKS;
            r_cfg.timeout_ticks   <= RST_TIMEOUT_TICKS;
            r_cfg.ticks_per_us    <= RST_TICKS_PER_US;
        end else if (cfg_wr) begin
            case (i_cfg.idx)
                REG_ENABLED:         r_cfg.enabled         <= i_cfg.data[0];
                REG_OVERSAMPLE_LOG2: r_cfg.oversample_log2 <= i_cfg.data[OVS_W-1:0];
                REG_CHARGE_TICKS:    r_cfg.charge_ticks    <= i_cfg.data[TICK_W-1:0];
                REG_SETTLE_TICKS:    r_cfg.settle_ticks    <= i_cfg.data[TICK_W-1:0];
                REG_TIMEOUT_TICKS:   r_cfg.timeout_ticks   <= i_cfg.data[TICK_W-1:0];
                REG_TICKS_PER_US:    r_cfg.ticks_per_us    <= i_cfg.data[TPU_W-1:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    rcds_seq #(
        .COUNT_WIDTH         (COUNT_WIDTH),
        .MAX_OVERSAMPLE_LOG2 (MAX_OVERSAMPLE_LOG2),
        .ACC_WIDTH           (ACC_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (push),
        .i_start_req  (i_in.start_req),
        .i_cap_level  (i_in.cap_level),
        .i_status_clr (status_clr),
        .i_cfg        (r_cfg),
        .o_res        (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_head <= seq_res;
                end else begin
                    r_tail <= seq_res;
                end
            end
            2'b01: begin
                r_head <= r_tail;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_head <= seq_res;
                end else begin
                    r_head <= r_tail;
                    r_tail <= seq_res;
                end
            end
            default: begin
                r_head <= r_head;
            end
        endcase
    end

    assign o_out.valid          = (r_cnt != 2'd0);
    assign o_out.pos_drive_en   = r_head.pos_drive_en;
    assign o_out.pos_level      = r_head.pos_level;
    assign o_out.neg_drive_en   = r_head.neg_drive_en;
    assign o_out.neg_level      = r_head.neg_level;
    assign o_out.probe_drive_en = r_head.probe_drive_en;
    assign o_out.probe_level    = r_head.probe_level;
    assign o_out.busy_res       = r_head.busy_res;
    assign o_out.done_res       = r_head.done_res;
    assign o_out.raw_average    = r_head.raw_average;
    assign o_out.status         = r_head.status;

endmodule

@@ verif/rcds_reading_checker.sv @@
`timescale 1ns / 100ps

module rcds_reading_checker
    import rcds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rcds_in_if   i_tick,
    rcds_out_if  i_res,
    rcds_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CHARGE,
        SEQ_DISCHARGE,
        SEQ_SETTLE,
        SEQ_REVERSE,
        SEQ_COMP,
        SEQ_NEUTRAL
    } seq_phase_e;

    localparam logic [TICK_W-1:0] TICK_SAT = '1;
    localparam logic [OVS_W-1:0]  OVS_MAX  = 4'd8;

    t_cfg                regs;
    seq_phase_e          phase;
    logic [TICK_W-1:0]   phase_ticks;
    logic [TICK_W-1:0]   discharge_count;
    logic [TICK_W-1:0]   whole_us;
    logic [TPU_W-1:0]    us_prescale;
    logic [SCOUNT_W-1:0] sample_count;
    logic [31:0]         acc;
    logic                last_cap;
    logic [STATUS_W-1:0] status_q;

    t_result seq_out_q[$];
    t_result got_res;
    t_result want_res;
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void reset_sequencer();
        regs.enabled         = 1'b0;
        regs.oversample_log2 = RST_OVERSAMPLE_LOG2;
        regs.charge_ticks    = RST_CHARGE_TICKS;
        regs.settle_ticks    = RST_SETTLE_TICKS;
        regs.timeout_ticks   = RST_TIMEOUT_TICKS;
        regs.ticks_per_us    = RST_TICKS_PER_US;
        phase           = SEQ_IDLE;
        phase_ticks     = '0;
        discharge_count = '0;
        whole_us        = '0;
        us_prescale     = '0;
        sample_count    = '0;
        acc             = '0;
        last_cap        = 1'b1;
        status_q        = ST_NOT_ENABLED;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENABLED: begin
                regs.enabled = data[0];
                if (data[0]) begin
                    status_q = ST_OK;
                end
            end
            REG_OVERSAMPLE_LOG2: regs.oversample_log2 = data[OVS_W-1:0];
            REG_CHARGE_TICKS:    regs.charge_ticks    = data[TICK_W-1:0];
            REG_SETTLE_TICKS:    regs.settle_ticks    = data[TICK_W-1:0];
            REG_TIMEOUT_TICKS:   regs.timeout_ticks   = data[TICK_W-1:0];
            REG_TICKS_PER_US:    regs.ticks_per_us    = data[TPU_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic phase_elapsed(logic [TICK_W-1:0] limit);
        if (phase_ticks != TICK_SAT) begin
            phase_ticks++;
        end
        return phase_ticks >= limit;
    endfunction

    function automatic void conclude(logic [STATUS_W-1:0] code, logic [RAW_W-1:0] raw,
                                     inout t_result r);
        r.done_res    = 1'b1;
        r.raw_average = raw;
        status_q      = code;
        phase         = SEQ_IDLE;
        phase_ticks   = '0;
        us_prescale   = '0;
    endfunction

    function automatic t_result sequencer_tick(logic start, logic cap);
        t_result           r;
        logic              fall;
        logic [TPU_W-1:0]  tpu;
        logic [OVS_W-1:0]  ovs;
        logic [TICK_W-1:0] n;
        logic [32:0]       sum;
        logic [31:0]       avg;
        r    = '0;
        fall = last_cap && !cap;
        tpu  = (regs.ticks_per_us == '0) ? TPU_W'(1) : regs.ticks_per_us;
        ovs  = (regs.oversample_log2 > OVS_MAX) ? OVS_MAX : regs.oversample_log2;
        case (phase)
            SEQ_IDLE: begin
                if (start) begin
                    if (!regs.enabled) begin
                        conclude(ST_NOT_ENABLED, '0, r);
                    end else begin
                        acc          = '0;
                        sample_count = '0;
                        phase        = SEQ_CHARGE;
                        phase_ticks  = '0;
                    end
                end
            end
            SEQ_CHARGE: begin
                if (phase_elapsed(regs.charge_ticks)) begin
                    phase       = SEQ_DISCHARGE;
                    phase_ticks = '0;
                end
            end
            SEQ_DISCHARGE: begin
                n = (phase_ticks != TICK_SAT) ? phase_ticks + 1'b1 : TICK_SAT;
                if (fall) begin
                    discharge_count = n;
                    whole_us        = discharge_count / tpu;
                    if (whole_us == '0) begin
                        whole_us = TICK_W'(1);
                    end
                    phase       = SEQ_SETTLE;
                    phase_ticks = '0;
                end else if (n >= regs.timeout_ticks) begin
                    conclude(ST_TIMEOUT, '0, r);
                end else begin
                    phase_ticks = n;
                end
            end
            SEQ_SETTLE: begin
                if (phase_elapsed(regs.settle_ticks)) begin
                    phase       = SEQ_REVERSE;
                    phase_ticks = '0;
                end
            end
            SEQ_REVERSE: begin
                if (phase_elapsed(regs.charge_ticks)) begin
                    phase       = SEQ_COMP;
                    phase_ticks = '0;
                    us_prescale = '0;
                end
            end
            SEQ_COMP: begin
                us_prescale++;
                if (us_prescale >= tpu) begin
                    us_prescale = '0;
                    if (phase_elapsed(whole_us)) begin
                        phase       = SEQ_NEUTRAL;
                        phase_ticks = '0;
                    end
                end
            end
            SEQ_NEUTRAL: begin
                if (phase_elapsed(regs.settle_ticks)) begin
                    sum = acc + discharge_count;
                    acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (sample_count != '1) begin
                        sample_count++;
                    end
                    phase_ticks = '0;
                    if (int'(sample_count) >= (1 << ovs)) begin
                        avg = acc >> ovs;
                        if (avg == '0) begin
                            conclude(ST_INVALID, '0, r);
                        end else if (avg > 32'h00FF_FFFF) begin
                            conclude(ST_OK, '1, r);
                        end else begin
                            conclude(ST_OK, avg[RAW_W-1:0], r);
                        end
                    end else begin
                        phase = SEQ_CHARGE;
                    end
                end
            end
            default: begin
                phase       = SEQ_IDLE;
                phase_ticks = '0;
            end
        endcase
        last_cap = cap;

        case (phase)
            SEQ_CHARGE: begin
                r.pos_drive_en = 1'b1;
                r.pos_level    = 1'b1;
                r.neg_drive_en = 1'b1;
            end
            SEQ_DISCHARGE: begin
                r.neg_drive_en   = 1'b1;
                r.probe_drive_en = 1'b1;
            end
            SEQ_SETTLE: begin
                r.pos_drive_en = 1'b1;
                r.neg_drive_en = 1'b1;
            end
            SEQ_REVERSE: begin
                r.pos_drive_en = 1'b1;
                r.neg_drive_en = 1'b1;
                r.neg_level    = 1'b1;
            end
            SEQ_COMP: begin
                r.neg_drive_en   = 1'b1;
                r.neg_level      = 1'b1;
                r.probe_drive_en = 1'b1;
                r.probe_level    = 1'b1;
            end
            SEQ_NEUTRAL: begin
                r.pos_drive_en = 1'b1;
                r.pos_level    = 1'b1;
                r.neg_drive_en = 1'b1;
                r.neg_level    = 1'b1;
            end
            default: ;
        endcase
        r.busy_res = (phase != SEQ_IDLE);
        r.status   = status_q;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_sequencer();
            seq_out_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                write_reg(i_cfg.idx, i_cfg.data);
            end
            if (i_res.valid && i_res.ready) begin
                got_res.pos_drive_en   = i_res.pos_drive_en;
                got_res.pos_level      = i_res.pos_level;
                got_res.neg_drive_en   = i_res.neg_drive_en;
                got_res.neg_level      = i_res.neg_level;
                got_res.probe_drive_en = i_res.probe_drive_en;
                got_res.probe_level    = i_res.probe_level;
                got_res.busy_res       = i_res.busy_res;
                got_res.done_res       = i_res.done_res;
                got_res.raw_average    = i_res.raw_average;
                got_res.status         = i_res.status;
                if (seq_out_q.size() == 0) begin
                    $display("%0t: transfer with nothing pending, expected none actual %h",
                             $time, got_res);
                    fail_count++;
                end else begin
                    want_res = seq_out_q.pop_front();
                    check_field("pos_drive_en", want_res.pos_drive_en, got_res.pos_drive_en);
                    check_field("pos_level", want_res.pos_level, got_res.pos_level);
                    check_field("neg_drive_en", want_res.neg_drive_en, got_res.neg_drive_en);
                    check_field("neg_level", want_res.neg_level, got_res.neg_level);
                    check_field("probe_drive_en", want_res.probe_drive_en,
                                got_res.probe_drive_en);
                    check_field("probe_level", want_res.probe_level, got_res.probe_level);
                    check_field("busy_res", want_res.busy_res, got_res.busy_res);
                    check_field("done_res", want_res.done_res, got_res.done_res);
                    check_field("raw_average", want_res.raw_average, got_res.raw_average);
                    check_field("status", want_res.status, got_res.status);
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                seq_out_q.push_back(sequencer_tick(i_tick.start_req, i_tick.cap_level));
            end
        end
        o_pending <= seq_out_q.size();
    end

endmodule

@@ verif/tb_rc_discharge_conductivity_sequencer.sv @@
`timescale 1ns / 100ps

module tb_rc_discharge_conductivity_sequencer;
    import rcds_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    bit          no_idle;
    bit          cap_lvl;
    int unsigned cap_left;
    int unsigned hi_max;
    int unsigned lo_max;

    rcds_in_if  in_if();
    rcds_out_if out_if();
    rcds_cfg_if cfg_if();

    rc_discharge_conductivity_sequencer u_dut (
        .i_clk,
        .i_rst_n,
        .i_in  (in_if),
        .o_out (out_if),
        .i_cfg (cfg_if)
    );

    rcds_reading_checker u_checker (
        .i_clk,
        .i_rst_n,
        .i_tick       (in_if),
        .i_res        (out_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #2000000;
        $display("tb_rc_discharge_conductivity_sequencer: FAIL");
        $finish;
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= no_idle || ($urandom_range(99) >= 22);
        end
    end

    function automatic bit next_cap();
        if (cap_left == 0) begin
            cap_lvl  = !cap_lvl;
            cap_left = cap_lvl ? $urandom_range(1, hi_max) : $urandom_range(1, lo_max);
        end
        cap_left--;
        return cap_lvl;
    endfunction

    function automatic void set_cap_runs(int unsigned hi, int unsigned lo);
        hi_max = hi;
        lo_max = lo;
    endfunction

    task automatic send_tick(logic start, logic cap);
        if (!no_idle && $urandom_range(99) < 22) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.start_req <= start;
        in_if.cap_level <= cap;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic run_ticks(int n, int unsigned start_pct);
        repeat (n) send_tick($urandom_range(99) < start_pct, next_cap());
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    task automatic load_settings(logic en, logic [OVS_W-1:0] ovs, logic [TICK_W-1:0] chg,
                                 logic [TICK_W-1:0] stl, logic [TICK_W-1:0] tmo,
                                 logic [TPU_W-1:0] tpu);
        drain();
        write_reg(REG_ENABLED, CFG_DATA_W'(en));
        write_reg(REG_OVERSAMPLE_LOG2, CFG_DATA_W'(ovs));
        write_reg(REG_CHARGE_TICKS, chg);
        write_reg(REG_SETTLE_TICKS, stl);
        write_reg(REG_TIMEOUT_TICKS, tmo);
        write_reg(REG_TICKS_PER_US, CFG_DATA_W'(tpu));
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int k;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.start_req <= 1'b0;
        in_if.cap_level <= 1'b1;
        cfg_if.valid    <= 1'b0;
        cfg_if.idx      <= REG_ENABLED;
        cfg_if.data     <= '0;
        cap_lvl  = 1'b1;
        cap_left = 0;
        no_idle  = 1'b0;
        set_cap_runs(4, 2);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start while disabled
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // hold cap high through discharge: timeout, then edge on the timeout tick
        load_settings(1'b1, 4'd0, 24'd1, 24'd1, 24'd7, 8'd1);
        for (k = 0; k < 9; k++) send_tick(k == 0, 1'b1);
        for (k = 0; k < 9; k++) send_tick(k == 0, k != 8);
        run_ticks(12, 0);

        // zero durations and zero ticks_per_us
        set_cap_runs(6, 3);
        load_settings(1'b1, 4'd1, 24'd0, 24'd0, 24'd0, 8'd0);
        run_ticks(60, 20);

        // park a reading in a maximal charge, then shorten it under way
        load_settings(1'b1, 4'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 8'hFF);
        run_ticks(40, 30);
        load_settings(1'b1, 4'd2, 24'd2, 24'd1, 24'd30, 8'd3);
        run_ticks(60, 10);

        // long discharges without timeout
        set_cap_runs(150, 3);
        load_settings(1'b1, 4'd0, 24'd1, 24'd1, 24'hFF_FFFF, 8'd60);
        run_ticks(120, 5);

        // disabled while a reading may still run
        set_cap_runs(5, 2);
        load_settings(1'b0, 4'd3, 24'd1, 24'd1, 24'd20, 8'd2);
        run_ticks(40, 30);

        // oversample above maximum, clamped
        set_cap_runs(1, 1);
        load_settings(1'b1, 4'd15, 24'd1, 24'd1, 24'd40, 8'd1);
        no_idle = 1'b1;
        run_ticks(600, 5);
        no_idle = 1'b0;
        run_ticks(1100, 5);

        repeat (3) begin
            set_cap_runs($urandom_range(1, 12), $urandom_range(1, 4));
            load_settings($urandom_range(9) != 0, $urandom_range(3),
                          $urandom_range(0, 6), $urandom_range(0, 6),
                          $urandom_range(1, 40), $urandom_range(0, 5));
            run_ticks(60, $urandom_range(5, 40));
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_rc_discharge_conductivity_sequencer: PASS");
        end else begin
            $display("tb_rc_discharge_conductivity_sequencer: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rcds_pkg.sv
rtl/core/rcds_if.sv
rtl/core/rcds_seq.sv
rtl/core/rc_discharge_conductivity_sequencer.sv
verif/rcds_reading_checker.sv
verif/tb_rc_discharge_conductivity_sequencer.sv
